>>> sv/alfr_pkg.sv
package alfr_pkg;

	localparam int unsigned RING_LEN = 31;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned VALUE_W = 31;
	localparam int unsigned FRONT_OFS = 3;
	localparam int unsigned FILL_WORDS = RING_LEN - 1;
	localparam int unsigned DISCARD_COUNT = 310;

	localparam int unsigned WCNT_W = $clog2(FILL_WORDS);
	localparam int unsigned DCNT_W = $clog2(DISCARD_COUNT);

	localparam logic [WORD_W-1:0] ZERO_SUBST = 32'd123459876;
	localparam logic [16:0] SCHRAGE_Q = 17'd127773;
	localparam logic [14:0] SCHRAGE_A = 15'd16807;
	localparam logic [11:0] SCHRAGE_R = 12'd2836;
	localparam logic [WORD_W-1:0] PM_MOD = 32'h7fffffff;
	localparam logic [WORD_W-1:0] PM_RECIP = 32'((64'd1 << 48) / 64'(SCHRAGE_Q));

	localparam logic [WORD_W-1:0] DEFAULT_RING [RING_LEN] = '{
		32'h991539b1, 32'h16a5bce3, 32'h6774a4cd, 32'h3e01511e, 32'h4e508aaa,
		32'h61048c05, 32'hf5500617, 32'h846b7115, 32'h6a19892c, 32'h896a97af,
		32'hdb48f936, 32'h14898454, 32'h37ffd106, 32'hb58bff9c, 32'h59e17104,
		32'hcf918a49, 32'h09378c83, 32'h52c7a471, 32'h8d293ea9, 32'h1f4fc301,
		32'hc3db71be, 32'h39b44e1c, 32'hf8a44ef9, 32'h4c8b80b1, 32'h19edc328,
		32'h87bf4bdd, 32'hc9b240e5, 32'he9ee4b1b, 32'h4382aee7, 32'h535b6b41,
		32'hf3bec5da
	};

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FILL,
		ST_DISCARD
	} state_t;

	typedef struct packed {
		logic shift;
		logic inject;
	} cell_ctrl_t;

endpackage

>>> sv/alfr_cell.sv
module alfr_cell
	import alfr_pkg::*;
#(
	parameter logic [WORD_W-1:0] RESET_VAL = '0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cell_ctrl_t        ctrl,
	input  logic [WORD_W-1:0] nb_data,
	input  logic [WORD_W-1:0] inj_data,
	output logic [WORD_W-1:0] word
);

	logic [WORD_W-1:0] word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= RESET_VAL;
		end else if (ctrl.shift) begin
			word_q <= ctrl.inject ? inj_data : nb_data;
		end
	end

	assign word = word_q;

endmodule

>>> sv/alfr_pm.sv
module alfr_pm
	import alfr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [WORD_W-1:0] x_in,
	output logic              done,
	output logic [WORD_W-1:0] result
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [WORD_W-1:0] x_s1, x_s2;
	logic [63:0]       prod_s1;
	logic [15:0]       hi_s2;
	logic [WORD_W-1:0] hq_s2;
	logic [31:0]       a_s3;
	logic [27:0]       b_s3;
	logic [WORD_W-1:0] res_s4;

	logic [WORD_W-1:0] x_sub;
	logic [17:0]       lo_est;
	logic [16:0]       lo_fix;
	logic [15:0]       hi_fix;
	logic [32:0]       r_diff;
	logic [32:0]       r_fix;

	assign x_sub = (x_in == '0) ? ZERO_SUBST : x_in;

	always_comb begin
		lo_est = 18'(x_s2 - hq_s2);
		if (lo_est >= 18'(SCHRAGE_Q)) begin
			lo_fix = 17'(lo_est - 18'(SCHRAGE_Q));
			hi_fix = hi_s2 + 16'd1;
		end else begin
			lo_fix = lo_est[16:0];
			hi_fix = hi_s2;
		end
		r_diff = {1'b0, a_s3} - {5'b0, b_s3};
		r_fix = r_diff[32] ? r_diff + {1'b0, PM_MOD} : r_diff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		x_s1    <= x_sub;
		prod_s1 <= 64'(x_sub) * 64'(PM_RECIP);
		x_s2    <= x_s1;
		hi_s2   <= prod_s1[63:48];
		hq_s2   <= 32'(prod_s1[63:48] * SCHRAGE_Q);
		a_s3    <= 32'(lo_fix * SCHRAGE_A);
		b_s3    <= 28'(hi_fix * SCHRAGE_R);
		res_s4  <= r_fix[WORD_W-1:0];
	end

	assign done = v_s4;
	assign result = res_s4;

endmodule

>>> sv/additive_lagged_fibonacci_rng.sv
// Additive lagged Fibonacci random number source with lags 31 and 3.
// Requests arrive on the s_ channel: s_tuser selects the kind (0 asks for
// the next value, 1 reseeds from s_tdata). Results leave on the m_ channel,
// with the 31-bit value in m_tdata. A next request gives its value in the
// output register in the cycle after acceptance, and one request per cycle is
// taken as long as the receiver keeps up. The ring is a row of 31 word
// cells that shift toward the front on each step, so each step is one add.
// A reseed gives no result; it shifts in the seed and thirty Park-Miller
// words, each from the four-stage Schrage unit, and then runs 310
// discarded steps, during which s_tready is low. Reset loads the fixed
// default ring at once and leaves the block idle with no result pending.
// While the receiver stalls, the pending value holds and no new request
// is taken.
module additive_lagged_fibonacci_rng
	import alfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // seed[31:0]
	input  logic        s_tuser,  // mode[0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // value[30:0], zero[31]
);

	state_t state_q, state_d;

	logic [WORD_W-1:0] word [RING_LEN];
	cell_ctrl_t        ctrl [RING_LEN];
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] fill_data;
	logic [WORD_W-1:0] tail_in;
	logic [WORD_W-1:0] pm_result;
	logic              pm_done;
	logic              pm_start;
	logic              step;
	logic              fill_shift;
	logic              acc;
	logic              busy_q;
	logic [WCNT_W-1:0] word_cnt_q;
	logic [DCNT_W-1:0] disc_cnt_q;
	logic              out_valid_q;
	logic [VALUE_W-1:0] value_q;

	assign acc = s_tvalid && s_tready;
	assign sum = word[FRONT_OFS] + word[0];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && s_tuser) begin
					state_d = ST_FILL;
				end
			end
			ST_FILL: begin
				if (pm_done && word_cnt_q == WCNT_W'(FILL_WORDS - 1)) begin
					state_d = ST_DISCARD;
				end
			end
			ST_DISCARD: begin
				if (disc_cnt_q == DCNT_W'(DISCARD_COUNT - 1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		step = 1'b0;
		fill_shift = 1'b0;
		pm_start = 1'b0;
		fill_data = pm_result;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = !out_valid_q || m_tready;
				step = acc && !s_tuser;
				fill_shift = acc && s_tuser;
				fill_data = s_tdata;
			end
			ST_FILL: begin
				pm_start = !busy_q;
				fill_shift = pm_done;
			end
			ST_DISCARD: begin
				step = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q <= 1'b0;
			word_cnt_q <= '0;
			disc_cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pm_start) begin
				busy_q <= 1'b1;
			end else if (pm_done) begin
				busy_q <= 1'b0;
			end
			if (state_q == ST_IDLE) begin
				word_cnt_q <= '0;
			end else if (pm_done) begin
				word_cnt_q <= word_cnt_q + 1'b1;
			end
			if (state_q == ST_DISCARD) begin
				disc_cnt_q <= disc_cnt_q + 1'b1;
			end else begin
				disc_cnt_q <= '0;
			end
			if (acc && !s_tuser) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !s_tuser) begin
			value_q <= sum[WORD_W-1:1];
		end
	end

	assign tail_in = fill_shift ? fill_data : word[0];

	for (genvar k = 0; k < RING_LEN; k++) begin : g_cell
		assign ctrl[k].shift = step || fill_shift;
		assign ctrl[k].inject = step && (k == FRONT_OFS - 1);
		if (k == RING_LEN - 1) begin : g_tail
			alfr_cell #(.RESET_VAL(DEFAULT_RING[k])) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl[k]),
				.nb_data  (tail_in),
				.inj_data (sum),
				.word     (word[k])
			);
		end else begin : g_body
			alfr_cell #(.RESET_VAL(DEFAULT_RING[k])) u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl[k]),
				.nb_data  (word[k+1]),
				.inj_data (sum),
				.word     (word[k])
			);
		end
	end

	alfr_pm u_pm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (pm_start),
		.x_in   (word[RING_LEN-1]),
		.done   (pm_done),
		.result (pm_result)
	);

	assign m_tvalid = out_valid_q;
	assign m_tdata = {1'b0, value_q};

`ifndef ASSERT_OFF
	a_reseed_enters_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser) |=> state_q == ST_FILL)
		else $error("reseed request did not start the fill");
	a_pm_done_in_fill: assert property (@(posedge clk) disable iff (!arst_n)
		pm_done |-> (state_q == ST_FILL && busy_q))
		else $error("Schrage unit finished outside a fill");
	a_result_from_next: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready && !s_tuser))
		else $error("result appeared without a next request");
	a_no_step_and_fill: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && fill_shift))
		else $error("ring stepped and filled in the same cycle");
`endif

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import alfr_pkg::*;

	localparam logic MODE_NEXT = 1'b0;
	localparam logic MODE_RESEED = 1'b1;
	localparam int unsigned RUN_LIMIT = 400000;
	localparam int unsigned SETTLE_CYCLES = 600;
	localparam int unsigned HOLD_OFF_CYCLES = 200;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;  // seed[31:0]
	logic        s_tuser = 1'b0;  // mode[0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;  // value[30:0], zero[31]

	logic [WORD_W-1:0] lfg_ring [RING_LEN];
	int unsigned lfg_front;
	int unsigned lfg_rear;
	logic [VALUE_W-1:0] expected_values [$];

	int unsigned tx_idle_pct = 0;
	int unsigned rx_idle_pct = 0;
	int unsigned hold_left = 0;
	int unsigned cycle_count = 0;
	int unsigned request_count = 0;
	int unsigned reseed_count = 0;
	int unsigned checked_count = 0;
	int unsigned mismatch_count = 0;

	additive_lagged_fibonacci_rng DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned ring_advance(input int unsigned idx);
		return (idx >= RING_LEN - 1) ? 0 : idx + 1;
	endfunction

	// One minimal standard step with Schrage's method; the input is taken as unsigned.
	function automatic logic [WORD_W-1:0] park_miller(input logic [WORD_W-1:0] word);
		longint x;
		longint hi;
		longint lo;
		longint r;
		x = longint'(word);
		if (x == 0)
			x = longint'(ZERO_SUBST);
		hi = x / longint'(SCHRAGE_Q);
		lo = x % longint'(SCHRAGE_Q);
		r = longint'(SCHRAGE_A) * lo - longint'(SCHRAGE_R) * hi;
		if (r < 0)
			r += longint'(PM_MOD);
		return r[WORD_W-1:0];
	endfunction

	function automatic logic [VALUE_W-1:0] next_ring_value();
		logic [WORD_W-1:0] sum;
		sum = lfg_ring[lfg_front] + lfg_ring[lfg_rear];
		lfg_ring[lfg_front] = sum;
		lfg_front = ring_advance(lfg_front);
		lfg_rear = ring_advance(lfg_rear);
		return sum[WORD_W-1:1];
	endfunction

	function automatic void reseed_ring(input logic [WORD_W-1:0] seed);
		lfg_ring[0] = seed;
		for (int i = 1; i < RING_LEN; i++)
			lfg_ring[i] = park_miller(lfg_ring[i-1]);
		lfg_front = FRONT_OFS;
		lfg_rear = 0;
		for (int i = 0; i < DISCARD_COUNT; i++)
			void'(next_ring_value());
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("[additive_lagged_fibonacci_rng] ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left--;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		logic [VALUE_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_values.size() == 0) begin
				$error("value: no request pending, actual 0x%08h", m_tdata[VALUE_W-1:0]);
				mismatch_count++;
			end else begin
				want = expected_values.pop_front();
				checked_count++;
				if (m_tdata[VALUE_W-1:0] !== want) begin
					$error("value: expected 0x%08h, actual 0x%08h", want,
						m_tdata[VALUE_W-1:0]);
					mismatch_count++;
				end
			end
		end
	end

	task automatic send_request(input logic mode, input logic [31:0] seed);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= seed;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		request_count++;
		if (mode == MODE_RESEED) begin
			reseed_ring(seed);
			reseed_count++;
		end else begin
			expected_values.push_back(next_ring_value());
		end
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_values.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_default_ring();
		for (int i = 0; i < 8; i++)
			send_request(MODE_NEXT, $urandom);
	endtask

	task automatic test_reseed_edges();
		send_request(MODE_RESEED, 32'h00000000);
		repeat (3) send_request(MODE_NEXT, 32'hffffffff);
		send_request(MODE_RESEED, 32'hffffffff);
		repeat (3) send_request(MODE_NEXT, 32'h00000000);
		send_request(MODE_RESEED, 32'h80000000);
		repeat (2) send_request(MODE_NEXT, $urandom);
		send_request(MODE_RESEED, 32'h7fffffff);
		repeat (2) send_request(MODE_NEXT, $urandom);
		send_request(MODE_RESEED, 32'h00000001);
		repeat (2) send_request(MODE_NEXT, $urandom);
		drain_results();
	endtask

	task automatic test_random(input int unsigned count, input int unsigned tx_pct,
			input int unsigned rx_pct);
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < 3)
				send_request(MODE_RESEED, ($urandom_range(9) == 0) ? 32'd0 : $urandom);
			else
				send_request(MODE_NEXT, $urandom);
		end
		drain_results();
	endtask

	task automatic test_output_stall();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_left = HOLD_OFF_CYCLES;
		for (int i = 0; i < 20; i++)
			send_request(MODE_NEXT, $urandom);
		drain_results();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		tx_idle_pct = 16;
		rx_idle_pct = 86;
		test_default_ring();
		test_reseed_edges();
		test_random(270, 16, 86);
		test_output_stall();
		test_random(270, 86, 16);
		test_random(290, 0, 0);

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests with %0d reseeds; %0d values checked.", request_count,
			reseed_count, checked_count);
		$display("Idle mixes on both sides, a long output stall and edge seeds were run.");
		if (mismatch_count == 0 && expected_values.size() == 0) begin
			$display("[additive_lagged_fibonacci_rng] OK");
		end else begin
			$display("[additive_lagged_fibonacci_rng] ERROR");
		end
		$finish;
	end

	initial begin
		lfg_ring = DEFAULT_RING;
		lfg_front = FRONT_OFS;
		lfg_rear = 0;
	end

endmodule

>>> filelist.f
sv/alfr_pkg.sv
sv/alfr_cell.sv
sv/alfr_pm.sv
sv/additive_lagged_fibonacci_rng.sv
dv/testbench.sv
